// ===== src/aac_adts_rtp_packetizer_defines.svh =====
// Assertion macros for the AAC-hbr packetizer checker.
// No dependencies; included by the checker file.
`ifndef AAC_ADTS_RTP_PACKETIZER_DEFINES_SVH
`define AAC_ADTS_RTP_PACKETIZER_DEFINES_SVH

// Clocked on clk_i, off while rst_ni is low.
`define AAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same clock, checked during reset too.
`define AAP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/aap_pkg.sv =====
// Shared types and constants of the AAC-hbr packetizer.
// No dependencies; imported by every module of the block.
package aap_pkg;

  localparam int unsigned AU_HEADER_BYTES = 4;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);

  localparam logic [7:0] AU_HDR_B0 = 8'h00;
  localparam logic [7:0] AU_HDR_B1 = 8'h10;

  localparam logic [15:0] CAP_RESET = 16'd1400;

  localparam logic CFG_ADTS_MODE       = 1'b0;
  localparam logic CFG_PACKET_CAPACITY = 1'b1;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_SYNC  = 2'd1,
    ST_LEN   = 2'd2,
    ST_SHORT = 2'd3
  } status_e;

  // One queued command: a status beat, or a data byte optionally led by an AU header.
  typedef struct packed {
    logic       is_status;
    status_e    status;
    logic       hdr;
    logic [7:0] data;
    logic       pe;
    logic       mk;
    logic [7:0] au0;
    logic [7:0] au1;
  } cmd_t;

endpackage

// ===== src/aap_front.sv =====
// Front part: config registers, ADTS parse and packet split, one byte per cycle while the queue has room.
// Depends on aap_pkg; emits one command per byte that makes results.
module aap_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          first_byte_i,
  input  logic          last_byte_i,
  input  logic [15:0]   buffer_length_i,
  output logic          cmd_valid_o,
  output aap_pkg::cmd_t cmd_o
);
  import aap_pkg::*;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic        adts_q;
  logic [15:0] space_q;
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  hc_q, hc_d;
  logic [3:0]  hs_q, hs_d;
  logic [12:0] fl_q, fl_d;
  logic [15:0] hl_q, hl_d;
  logic [15:0] pl_q, pl_d;
  logic [15:0] seg_q, seg_d;
  logic [7:0]  a0_q, a0_d;
  logic [7:0]  a1_q, a1_d;

  // space per packet is kept precomputed; config must only be changed while idle (not enforced by the block itself)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adts_q  <= 1'b0;
      space_q <= CAP_RESET - 16'(AU_HEADER_BYTES);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ADTS_MODE: adts_q <= cfg_data_i[0];
        CFG_PACKET_CAPACITY: begin
          space_q <= (cfg_data_i > 16'(AU_HEADER_BYTES)) ?
                     cfg_data_i - 16'(AU_HEADER_BYTES) : 16'd1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    logic bad;
    bad     = 1'b0;
    phase_d = phase_q;
    hc_d    = hc_q;
    hs_d    = hs_q;
    fl_d    = fl_q;
    hl_d    = hl_q;
    pl_d    = pl_q;
    seg_d   = seg_q;
    a0_d    = a0_q;
    a1_d    = a1_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;

    if (first_byte_i) begin
      hl_d  = buffer_length_i;
      hc_d  = 4'd0;
      hs_d  = 4'd7;
      fl_d  = '0;
      seg_d = '0;
      pl_d  = '0;
      if (adts_q) begin
        phase_d = PH_HEADER;
      end else begin
        pl_d    = buffer_length_i;
        a0_d    = buffer_length_i[12:5];
        a1_d    = {buffer_length_i[4:0], 3'b000};
        phase_d = (buffer_length_i != 16'd0) ? PH_PAYLOAD : PH_IDLE;
      end
    end

    if (phase_d == PH_HEADER) begin
      case (hc_d)
        4'd0: begin
          if (data_byte_i != 8'hFF) begin
            cmd_valid_o = 1'b1; cmd_o.is_status = 1'b1; cmd_o.status = ST_SYNC; bad = 1'b1;
          end
        end
        4'd1: begin
          if (data_byte_i[7:4] != 4'hF) begin
            cmd_valid_o = 1'b1; cmd_o.is_status = 1'b1; cmd_o.status = ST_SYNC; bad = 1'b1;
          end
          hs_d = data_byte_i[0] ? 4'd7 : 4'd9;
        end
        4'd3: fl_d = {data_byte_i[1:0], 11'b0};
        4'd4: fl_d = fl_d | {2'b00, data_byte_i, 3'b000};
        4'd5: begin
          fl_d = fl_d | {10'b0, data_byte_i[7:5]};
          if ({3'b000, fl_d} > hl_d) begin
            cmd_valid_o = 1'b1; cmd_o.is_status = 1'b1; cmd_o.status = ST_LEN; bad = 1'b1;
          end else if (fl_d < {9'b0, hs_d}) begin
            cmd_valid_o = 1'b1; cmd_o.is_status = 1'b1; cmd_o.status = ST_SHORT; bad = 1'b1;
          end else begin
            pl_d = {3'b000, fl_d} - {12'b0, hs_d};
            a0_d = pl_d[12:5];
            a1_d = {pl_d[4:0], 3'b000};
          end
        end
        default: ;
      endcase
      if (bad) begin
        phase_d = PH_IDLE;
      end else begin
        hc_d = hc_d + 4'd1;
        if (hc_d >= hs_d) phase_d = (pl_d != 16'd0) ? PH_PAYLOAD : PH_IDLE;
        // header cut short by the end of the buffer
        if (last_byte_i && phase_d == PH_HEADER && hc_d <= 4'd5) begin
          cmd_valid_o = 1'b1; cmd_o.is_status = 1'b1; cmd_o.status = ST_LEN;
        end
      end
    end else if (phase_d == PH_PAYLOAD) begin
      if (pl_d == 16'd0) begin
        phase_d = PH_IDLE;
      end else begin
        if (seg_d == 16'd0) begin
          seg_d     = (space_q < pl_d) ? space_q : pl_d;
          cmd_o.hdr = 1'b1;
        end
        cmd_valid_o  = 1'b1;
        cmd_o.status = ST_DATA;
        cmd_o.data   = data_byte_i;
        cmd_o.pe     = (seg_d == 16'd1);
        cmd_o.mk     = (seg_d == pl_d);
        cmd_o.au0    = a0_d;
        cmd_o.au1    = a1_d;
        seg_d = seg_d - 16'd1;
        pl_d  = pl_d - 16'd1;
        if (pl_d == 16'd0) phase_d = PH_IDLE;
      end
    end

    if (last_byte_i) phase_d = PH_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hc_q    <= '0;
      hs_q    <= 4'd7;
      fl_q    <= '0;
      hl_q    <= '0;
      pl_q    <= '0;
      seg_q   <= '0;
      a0_q    <= '0;
      a1_q    <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      hs_q    <= hs_d;
      fl_q    <= fl_d;
      hl_q    <= hl_d;
      pl_q    <= pl_d;
      seg_q   <= seg_d;
      a0_q    <= a0_d;
      a1_q    <= a1_d;
    end
  end

endmodule

// ===== src/aap_cmdq.sv =====
// Short command queue between front and back parts.
// Depends on aap_pkg for cmd_t and depth.
module aap_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  aap_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output aap_pkg::cmd_t head_o
);
  import aap_pkg::*;

  cmd_t           mem_q [QDEPTH];
  logic [QAW-1:0] wptr_q, rptr_q;
  logic [QAW:0]   cnt_q;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i && !full_o) wptr_q <= wptr_q + 1'b1;
      if (pop_i && !empty_o) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (QAW+1)'(push_i && !full_o) - (QAW+1)'(pop_i && !empty_o);
    end
  end

endmodule

// ===== src/aap_back.sv =====
// Back part: expands the head command into result beats.
// Depends on aap_pkg; a data command with header gives five beats.
module aap_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  aap_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          done_o,
  output logic [7:0]    out_byte_o,
  output logic          packet_start_o,
  output logic          packet_end_o,
  output logic          marker_o,
  output logic [1:0]    status_o,
  output logic          run_last_o
);
  import aap_pkg::*;

  logic [2:0] cnt_q;
  logic       in_hdr;

  assign in_hdr = !cmd_i.is_status && cmd_i.hdr && (cnt_q != 3'(AU_HEADER_BYTES));
  assign done_o = valid_i && pop_i && !in_hdr;

  always_comb begin
    out_byte_o     = '0;
    packet_start_o = 1'b0;
    packet_end_o   = 1'b0;
    marker_o       = 1'b0;
    status_o       = cmd_i.status;
    run_last_o     = !in_hdr;
    if (!cmd_i.is_status) begin
      marker_o = cmd_i.mk;
      if (in_hdr) begin
        case (cnt_q[1:0])
          2'd0: begin out_byte_o = AU_HDR_B0; packet_start_o = 1'b1; end
          2'd1: out_byte_o = AU_HDR_B1;
          2'd2: out_byte_o = cmd_i.au0;
          default: out_byte_o = cmd_i.au1;
        endcase
      end else begin
        out_byte_o   = cmd_i.data;
        packet_end_o = cmd_i.pe;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (valid_i && pop_i) begin
      cnt_q <= in_hdr ? cnt_q + 3'd1 : 3'd0;
    end
  end

endmodule

// ===== src/aac_adts_rtp_packetizer.sv =====
// AAC-hbr RTP payload packetizer: ADTS check and strip, AU header, packet split.
// Data path: each command is registered in the command queue before its beats reach the ports.
// Throughput: one input byte per cycle while the queue is not full; each byte gives at most
// one command, and the back part drains one beat per cycle while pop is high (five beats for a
// packet's first byte), so a four-entry command queue sets how long a header burst can run before full rises.
// Reset: async active low; clears queue, parse state, and config to its defaults.
module aac_adts_rtp_packetizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input bytes
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic [15:0] buffer_length_i,
  // result beats
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        packet_start_o,
  output logic        packet_end_o,
  output logic        marker_o,
  output logic [1:0]  status_o,
  output logic        run_last_o
);
  import aap_pkg::*;

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  cmd_t head;
  logic head_done;

  // a byte is taken whenever the queue has room, even if it makes no result
  assign accept = push && !full;

  aap_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .accept_i    (accept),
    .data_byte_i,
    .first_byte_i,
    .last_byte_i,
    .buffer_length_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  aap_cmdq u_cmdq (
    .clk_i,
    .rst_ni,
    .push_i  (accept && cmd_valid),
    .wdata_i (cmd),
    .full_o  (full),
    .pop_i   (head_done),
    .empty_o (empty),
    .head_o  (head)
  );

  // head command retires on its run_last beat
  aap_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i (!empty),
    .cmd_i   (head),
    .pop_i   (pop),
    .done_o  (head_done),
    .out_byte_o,
    .packet_start_o,
    .packet_end_o,
    .marker_o,
    .status_o,
    .run_last_o
  );

endmodule

// ===== src/aap_checker.sv =====
// Port-level checker for the packetizer, bound to its top level.
// Depends on aap_pkg and aac_adts_rtp_packetizer_defines.svh.
`include "aac_adts_rtp_packetizer_defines.svh"

module aap_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       packet_start_o,
  input logic       packet_end_o,
  input logic       marker_o,
  input logic [1:0] status_o,
  input logic       run_last_o
);
  import aap_pkg::*;

  `AAP_ASSERT(a_status_clean, (!empty && status_o != ST_DATA) |-> (run_last_o && out_byte_o == 8'h00 && !packet_start_o && !packet_end_o && !marker_o), "status beat not clean")
  `AAP_ASSERT(a_start_hdr, (!empty && packet_start_o) |-> (out_byte_o == AU_HDR_B0 && !run_last_o && status_o == ST_DATA), "bad packet start beat")
  `AAP_ASSERT(a_end_last, (!empty && packet_end_o) |-> run_last_o, "packet end not on final beat")
  `AAP_ASSERT(a_hdr_seq, (!empty && pop && packet_start_o) |=> (!empty && out_byte_o == AU_HDR_B1 && !packet_start_o), "AU header sequence broken")
  `AAP_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(status_o)), "stalled beat changed")

endmodule

bind aac_adts_rtp_packetizer aap_checker u_aap_checker (.*);
